[hdl/cpo_pkg.sv]
`default_nettype none

package cpo_pkg;

  localparam int MAX_VERTICES = 8;

  localparam int IDX_W     = $clog2(MAX_VERTICES);
  localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int TOT_W     = CNT_W + 1;
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  localparam int COORD_W  = 16;
  localparam int VERTEX_W = 2 * COORD_W;
  localparam int AXIS_W   = COORD_W + 1;
  localparam int PROD_W   = COORD_W + AXIS_W;
  localparam int PROJ_W   = PROD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [PROJ_W-1:0]  proj_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic pol_b;
  } proj_ctl_t;

  typedef struct packed {
    logic busy;
    logic sep;
  } proj_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE0,
    ST_EDGE1,
    ST_AXIS,
    ST_PROJ,
    ST_DRAIN,
    ST_JUDGE,
    ST_FINISH
  } cpo_state_t;

endpackage

`default_nettype wire

[hdl/cpo_ram.sv]
`default_nettype none

module cpo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/cpo_proj.sv]
`default_nettype none

module cpo_proj (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cpo_pkg::proj_ctl_t ctl,
  input  wire cpo_pkg::coord_t    vx,
  input  wire cpo_pkg::coord_t    vy,
  input  wire cpo_pkg::axis_t     ax,
  input  wire cpo_pkg::axis_t     ay,
  output      cpo_pkg::proj_sts_t sts
);

  import cpo_pkg::*;

  prod_t mx;
  prod_t my;
  logic  p2_valid;
  logic  p2_pol;
  proj_t p;
  proj_t a_lo, a_hi, b_lo, b_hi;
  logic  a_any, b_any;

  // stage 2: products
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= ctl.valid;
    end
    if (ctl.valid) begin
      mx     <= prod_t'(vx) * prod_t'(ax);
      my     <= prod_t'(vy) * prod_t'(ay);
      p2_pol <= ctl.pol_b;
    end
  end

  assign p = proj_t'(mx) + proj_t'(my);

  // stage 3: interval update
  always_ff @(posedge clk) begin
    if (rst) begin
      a_any <= 1'b0;
      b_any <= 1'b0;
    end else if (ctl.clear) begin
      a_any <= 1'b0;
      b_any <= 1'b0;
    end else if (p2_valid) begin
      if (p2_pol) begin
        b_any <= 1'b1;
      end else begin
        a_any <= 1'b1;
      end
    end
    if (!ctl.clear && p2_valid) begin
      if (p2_pol) begin
        if (!b_any || p < b_lo) b_lo <= p;
        if (!b_any || p > b_hi) b_hi <= p;
      end else begin
        if (!a_any || p < a_lo) a_lo <= p;
        if (!a_any || p > a_hi) a_hi <= p;
      end
    end
  end

  assign sts.busy = p2_valid;
  assign sts.sep  = (a_hi < b_lo) || (b_hi < a_lo);

endmodule

`default_nettype wire

[hdl/convex_polygon_overlap_test.sv]
// Channel  Dir  Signals                          Contents
// s_*      in   tvalid tready tdata tuser tlast  vertex; tuser = polygon_b, tlast = last
// m_*      out  tvalid tready tdata tuser        test result; tuser = bad_input
//
// The last vertex starts a test: for each edge of A and then of B, the sequencer
// fetches both ends of the edge from the single-read-port vertex RAM, reads every
// vertex of A and B, then drains the projection pipeline and judges.
// A separating edge ends the test early; a bad pair goes straight to the result.
// Reset clears counts and control only; the vertex RAM is not cleared.
// Vertices are accepted while a result waits on m_*; a new result waits for it.
`default_nettype none

module convex_polygon_overlap_test (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // vertex_x[15:0], vertex_y[31:16]
  input  wire logic        s_tuser,   // polygon_b
  input  wire logic        s_tlast,   // last
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [7:0]  m_tdata,   // overlap[0], zero[7:1]
  output      logic        m_tuser    // bad_input
);

  import cpo_pkg::*;

  cpo_state_t state, state_next;

  logic [CNT_W-1:0]  a_count, b_count, a_count_next, b_count_next;
  logic              ovf, ovf_next;
  logic [CNT_W-1:0]  na, nb, n_e;
  logic              ep;
  logic [IDX_W-1:0]  ek, nxt;
  logic              last_k;
  logic [TOT_W-1:0]  j, total, j_b;
  logic              j_in_b;
  coord_t            x0, y0, rd_x, rd_y;
  axis_t             ax, ay;
  logic              p1_valid, p1_pol;
  logic              res_hit, res_bad;
  logic              s_acc, a_room, b_room, bad_next, out_load;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [VERTEX_W-1:0] ram_rdata;

  proj_ctl_t pctl;
  proj_sts_t psts;

  assign s_acc  = s_tvalid && s_tready;
  assign a_room = a_count < CNT_W'(MAX_VERTICES);
  assign b_room = b_count < CNT_W'(MAX_VERTICES);

  always_comb begin
    a_count_next = a_count;
    b_count_next = b_count;
    ovf_next     = ovf;
    if (s_acc) begin
      if (s_tuser) begin
        if (b_room) b_count_next = b_count + CNT_W'(1);
        else        ovf_next     = 1'b1;
      end else begin
        if (a_room) a_count_next = a_count + CNT_W'(1);
        else        ovf_next     = 1'b1;
      end
    end
  end

  assign bad_next  = ovf_next || (a_count_next == '0) || (b_count_next == '0);
  assign ram_we    = s_acc && (s_tuser ? b_room : a_room);
  assign ram_waddr = {s_tuser, s_tuser ? b_count[IDX_W-1:0] : a_count[IDX_W-1:0]};

  assign n_e    = ep ? nb : na;
  assign last_k = (CNT_W'(ek) + CNT_W'(1)) == n_e;
  assign nxt    = last_k ? '0 : ek + IDX_W'(1);
  assign total  = TOT_W'(na) + TOT_W'(nb);
  assign j_in_b = j >= TOT_W'(na);
  assign j_b    = j - TOT_W'(na);

  assign rd_x = ram_rdata[COORD_W-1:0];
  assign rd_y = ram_rdata[VERTEX_W-1:COORD_W];

  cpo_ram #(
    .WIDTH (VERTEX_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cpo_proj u_proj (
    .clk (clk),
    .rst (rst),
    .ctl (pctl),
    .vx  (rd_x),
    .vy  (rd_y),
    .ax  (ax),
    .ay  (ay),
    .sts (psts)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_acc && s_tlast) state_next = bad_next ? ST_FINISH : ST_EDGE0;
      end
      ST_EDGE0: state_next = ST_EDGE1;
      ST_EDGE1: state_next = ST_AXIS;
      ST_AXIS:  state_next = ST_PROJ;
      ST_PROJ: begin
        if (j == total - TOT_W'(1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1_valid && !psts.busy) state_next = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (psts.sep || (last_k && ep)) state_next = ST_FINISH;
        else                             state_next = ST_EDGE0;
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    ram_raddr  = '0;
    pctl.clear = 1'b0;
    pctl.valid = p1_valid;
    pctl.pol_b = p1_pol;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_EDGE0:  ram_raddr = {ep, ek};
      ST_EDGE1:  ram_raddr = {ep, nxt};
      ST_AXIS:   pctl.clear = 1'b1;
      ST_PROJ: begin
        ram_raddr = j_in_b ? {1'b1, j_b[IDX_W-1:0]} : {1'b0, j[IDX_W-1:0]};
      end
      ST_DRAIN:  ;
      ST_JUDGE:  ;
      ST_FINISH: out_load = !m_tvalid || m_tready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      a_count  <= '0;
      b_count  <= '0;
      ovf      <= 1'b0;
      p1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= (state == ST_PROJ);
      if (s_acc && s_tlast) begin
        a_count <= '0;
        b_count <= '0;
        ovf     <= 1'b0;
      end else begin
        a_count <= a_count_next;
        b_count <= b_count_next;
        ovf     <= ovf_next;
      end
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    p1_pol <= j_in_b;
    if (s_acc && s_tlast) begin
      na      <= a_count_next;
      nb      <= b_count_next;
      res_bad <= bad_next;
      res_hit <= 1'b0;
      ep      <= 1'b0;
      ek      <= '0;
    end
    if (state == ST_EDGE1) begin
      x0 <= rd_x;
      y0 <= rd_y;
    end
    if (state == ST_AXIS) begin
      ax <= axis_t'(y0) - axis_t'(rd_y);
      ay <= axis_t'(rd_x) - axis_t'(x0);
      j  <= '0;
    end
    if (state == ST_PROJ) begin
      j <= j + TOT_W'(1);
    end
    if (state == ST_JUDGE) begin
      res_hit <= !psts.sep && last_k && ep;
      if (!psts.sep && !(last_k && ep)) begin
        if (last_k) begin
          ep <= 1'b1;
          ek <= '0;
        end else begin
          ek <= ek + IDX_W'(1);
        end
      end
    end
    if (out_load) begin
      m_tdata <= {7'b0, res_hit};
      m_tuser <= res_bad;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    a_count <= CNT_W'(MAX_VERTICES) && b_count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  bad_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[0])
    else $error("bad pair reported with overlap");

  judge_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_JUDGE |-> !p1_valid && !psts.busy)
    else $error("judge before projection pipeline drained");

  last_starts_test: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tlast |=> state != ST_IDLE)
    else $error("last vertex did not start a test");

  finish_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && m_tvalid && !m_tready |=> state == ST_FINISH && m_tvalid)
    else $error("result overwrote a pending transaction");

endmodule

`default_nettype wire

[test/convex_polygon_overlap_test_tb.sv]
`default_nettype none

module convex_polygon_overlap_test_tb;
  import cpo_pkg::*;

  typedef struct packed {
    logic overlap;
    logic bad_input;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;

  int src_idle_pct = 33;
  int sink_idle_pct = 74;
  int items_sent = 0;
  int fail_count = 0;

  coord_t   vx [2][MAX_VERTICES];
  coord_t   vy [2][MAX_VERTICES];
  int       vcnt [2] = '{0, 0};
  bit       store_overflow = 1'b0;
  verdict_t expected_verdicts [$];
  verdict_t got;

  convex_polygon_overlap_test i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic bit axis_separates(longint ax, longint ay);
    longint lo [2];
    longint hi [2];
    longint p;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < vcnt[s]; k++) begin
        p = longint'(vx[s][k]) * ax + longint'(vy[s][k]) * ay;
        if (k == 0 || p < lo[s]) lo[s] = p;
        if (k == 0 || p > hi[s]) hi[s] = p;
      end
    end
    return (hi[0] < lo[1]) || (hi[1] < lo[0]);
  endfunction

  function automatic verdict_t judge_pair();
    verdict_t v;
    int nx;
    longint dx;
    longint dy;
    v.bad_input = store_overflow || vcnt[0] == 0 || vcnt[1] == 0;
    v.overlap = 1'b0;
    if (!v.bad_input) begin
      v.overlap = 1'b1;
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < vcnt[s]; k++) begin
          nx = (k + 1 < vcnt[s]) ? k + 1 : 0;
          dx = longint'(vx[s][nx]) - longint'(vx[s][k]);
          dy = longint'(vy[s][nx]) - longint'(vy[s][k]);
          if (axis_separates(-dy, dx)) v.overlap = 1'b0;
        end
      end
    end
    return v;
  endfunction

  function automatic void record_vertex(bit pb, coord_t x, coord_t y, bit lst);
    if (vcnt[pb] < MAX_VERTICES) begin
      vx[pb][vcnt[pb]] = x;
      vy[pb][vcnt[pb]] = y;
      vcnt[pb]++;
    end else begin
      store_overflow = 1'b1;
    end
    if (lst) begin
      expected_verdicts.push_back(judge_pair());
      vcnt[0] = 0;
      vcnt[1] = 0;
      store_overflow = 1'b0;
    end
  endfunction

  task automatic send_vertex(bit pb, int x, int y, bit lst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {coord_t'(y), coord_t'(x)};
    s_tuser  <= pb;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    record_vertex(pb, coord_t'(x), coord_t'(y), lst);
    items_sent++;
  endtask

  task automatic wait_for_verdicts();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transaction with no test pending");
        fail_count++;
      end else begin
        got = expected_verdicts.pop_front();
        if (m_tdata[0] !== got.overlap) begin
          $error("overlap: expected %0b, actual %0b", got.overlap, m_tdata[0]);
          fail_count++;
        end
        if (m_tuser !== got.bad_input) begin
          $error("bad_input: expected %0b, actual %0b", got.bad_input, m_tuser);
          fail_count++;
        end
        if (m_tdata[7:1] !== 7'd0) begin
          $error("m_tdata[7:1]: expected 0, actual %0h", m_tdata[7:1]);
          fail_count++;
        end
      end
    end
  end

  function automatic int octant_cos(int d);
    case (d)
      0:       return 1000;
      1, 7:    return 707;
      2, 6:    return 0;
      3, 5:    return -707;
      default: return -1000;
    endcase
  endfunction

  function automatic int rand_span(int m);
    return int'($urandom_range(2 * m)) - m;
  endfunction

  function automatic int clamp_center(int c, int r);
    if (c < -32768 + r) return -32768 + r;
    if (c > 32767 - r) return 32767 - r;
    return c;
  endfunction

  function automatic int pick_radius();
    return ($urandom_range(4) == 0) ? int'($urandom_range(1, 16000))
                                    : int'($urandom_range(0, 300));
  endfunction

  // n of the eight octant directions, in order, scaled per axis: always convex
  task automatic send_convex(bit pb, int cx, int cy, int rx, int ry, int n, bit close_pair);
    int need;
    need = n;
    for (int d = 0; d < 8; d++) begin
      if ($urandom_range(7 - d) < need) begin
        need--;
        send_vertex(pb, cx + octant_cos(d) * rx / 1000,
                    cy + octant_cos((d + 6) % 8) * ry / 1000, close_pair && need == 0);
      end
    end
  endtask

  task automatic send_random_pair();
    int kind;
    int na;
    int nb;
    int rxa;
    int rya;
    int rxb;
    int ryb;
    int cxa;
    int cya;
    int cxb;
    int cyb;
    bit pb;
    kind = $urandom_range(99);
    if (kind < 75) begin
      na  = $urandom_range(1, MAX_VERTICES);
      nb  = $urandom_range(1, MAX_VERTICES);
      rxa = pick_radius();
      rya = pick_radius();
      rxb = pick_radius();
      ryb = pick_radius();
      cxa = clamp_center(rand_span(32767), rxa);
      cya = clamp_center(rand_span(32767), rya);
      cxb = clamp_center(cxa + rand_span((rxa + rxb) * 3 / 2 + 1), rxb);
      cyb = clamp_center(cya + rand_span((rya + ryb) * 3 / 2 + 1), ryb);
      if ($urandom_range(9) == 0) begin
        send_convex(1'b1, cxb, cyb, rxb, ryb, nb, 1'b0);
        send_convex(1'b0, cxa, cya, rxa, rya, na, 1'b1);
      end else begin
        send_convex(1'b0, cxa, cya, rxa, rya, na, 1'b0);
        send_convex(1'b1, cxb, cyb, rxb, ryb, nb, 1'b1);
      end
    end else if (kind < 87) begin
      na = $urandom_range(1, 12);
      for (int k = 0; k < na; k++)
        send_vertex(1'($urandom_range(1)), $urandom, $urandom, k == na - 1);
    end else if (kind < 94) begin
      pb = 1'($urandom_range(1));
      na = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 3);
      nb = $urandom_range(1, 3);
      for (int k = 0; k < na; k++)
        send_vertex(pb, $urandom, $urandom, 1'b0);
      for (int k = 0; k < nb; k++)
        send_vertex(!pb, $urandom, $urandom, k == nb - 1);
    end else begin
      pb = 1'($urandom_range(1));
      na = $urandom_range(1, 4);
      for (int k = 0; k < na; k++)
        send_vertex(pb, $urandom, $urandom, k == na - 1);
    end
  endtask

  task automatic test_point_polygons();
    send_vertex(1'b0, -32768, -32768, 1'b0);
    send_vertex(1'b1, 32767, 32767, 1'b1);
  endtask

  task automatic test_crossing_segments();
    send_vertex(1'b0, -32768, 32767, 1'b0);
    send_vertex(1'b0, 32767, -32768, 1'b0);
    send_vertex(1'b1, -32768, -32768, 1'b0);
    send_vertex(1'b1, 32767, 32767, 1'b1);
  endtask

  task automatic test_separated_segments();
    send_vertex(1'b0, 0, 0, 1'b0);
    send_vertex(1'b0, 100, 0, 1'b0);
    send_vertex(1'b1, 100, 10, 1'b0);
    send_vertex(1'b1, 0, 10, 1'b1);
  endtask

  task automatic test_repeated_vertex();
    send_vertex(1'b0, 5, -7, 1'b0);
    send_vertex(1'b0, 5, -7, 1'b0);
    send_vertex(1'b1, 5, -7, 1'b1);
  endtask

  task automatic test_empty_polygons();
    send_vertex(1'b1, 3, 4, 1'b1);
    send_vertex(1'b0, -1, -1, 1'b1);
  endtask

  task automatic test_store_overflow();
    for (int k = 0; k <= MAX_VERTICES; k++)
      send_vertex(1'b0, k * 10, -k, 1'b0);
    send_vertex(1'b1, 0, 0, 1'b1);
  endtask

  task automatic test_random_pairs(int n_items, int src_pct, int sink_pct);
    int target;
    wait_for_verdicts();
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 3) wait_for_verdicts();
      send_random_pair();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_point_polygons();
    test_crossing_segments();
    test_separated_segments();
    test_repeated_vertex();
    test_empty_polygons();
    test_store_overflow();
    test_random_pairs(340, 33, 74);
    test_random_pairs(340, 74, 33);
    test_random_pairs(340, 0, 0);
    wait_for_verdicts();
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS convex_polygon_overlap_test");
    end else begin
      $display("FAIL convex_polygon_overlap_test");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("FAIL convex_polygon_overlap_test");
    $finish;
  end

endmodule

`default_nettype wire
